>>> rtl/core/ilst_pkg.sv
// Shared constants, codes and types of the indexed shift list.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package ilst_pkg;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned COORD_BITS = 8;

  // Fixed field widths of the channels
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned FIELD_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  // Compare width: wide enough for both a length and a raw position
  localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  // Read gather: cells are OR-reduced in groups, groups in a second step
  localparam int unsigned GROUP_SIZE = 16;
  localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_RM_HEAD  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RM_TAIL  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RM_AT    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_RD_AT    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RD_HEAD  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_RD_TAIL  = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [FIELD_W-1:0]    sym;
  } entry_t;

  // Broadcast to every cell for one command
  typedef struct packed {
    logic             ins;
    logic             rm;
    logic             rd;
    logic [CMP_W-1:0] at;
    logic [CMP_W-1:0] len;
    logic [CMP_W-1:0] last;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/ilst_cmd_if.sv
// Command channel of the indexed shift list: valid/ready plus command fields.
// Depends on ilst_pkg for field widths.
`default_nettype none

interface ilst_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [ilst_pkg::CMD_W-1:0]    command;
  logic [ilst_pkg::POS_W-1:0]    position;
  logic [ilst_pkg::FIELD_W-1:0]  coord_x;
  logic [ilst_pkg::FIELD_W-1:0]  coord_y;
  logic [ilst_pkg::FIELD_W-1:0]  glyph;

  modport source (output valid, command, position, coord_x, coord_y, glyph, input ready);
  modport sink   (input valid, command, position, coord_x, coord_y, glyph, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ilst_res_if.sv
// Result channel of the indexed shift list: valid/ready plus result fields.
// Depends on ilst_pkg for field widths.
`default_nettype none

interface ilst_res_if;
  logic                           valid;
  logic                           ready;
  logic [ilst_pkg::STATUS_W-1:0]  status;
  logic [ilst_pkg::FIELD_W-1:0]   read_x;
  logic [ilst_pkg::FIELD_W-1:0]   read_y;
  logic [ilst_pkg::FIELD_W-1:0]   read_glyph;
  logic [ilst_pkg::COUNT_W-1:0]   count;

  modport source (output valid, status, read_x, read_y, read_glyph, count, input ready);
  modport sink   (input valid, status, read_x, read_y, read_glyph, count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ilst_cell.sv
// One slot of the list row: holds an entry, takes from a neighbour on a shift.
// Depends on ilst_pkg (entry_t, ctrl_t).
`default_nettype none

module ilst_cell (
  input  wire logic            clk_i,
  input  wire logic [ilst_pkg::CMP_W-1:0] idx_i,
  input  wire ilst_pkg::ctrl_t  ctrl_i,
  input  wire ilst_pkg::entry_t new_i,
  input  wire ilst_pkg::entry_t left_i,
  input  wire ilst_pkg::entry_t right_i,
  output ilst_pkg::entry_t     ent_o,
  output ilst_pkg::entry_t     rd_o
);

  ilst_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins) begin
      if (idx_i == ctrl_i.at) begin
        ent_d = new_i;
      end else if (idx_i > ctrl_i.at && idx_i <= ctrl_i.len) begin
        ent_d = left_i;
      end
    end else if (ctrl_i.rm) begin
      // clear the vacated tail slot, pull the rest down
      if (idx_i == ctrl_i.last) begin
        ent_d = '0;
      end else if (idx_i >= ctrl_i.at && idx_i < ctrl_i.last) begin
        ent_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign rd_o  = (ctrl_i.rd && idx_i == ctrl_i.at) ? ent_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/ilst_gather.sv
// Two-step OR tree that collects the one selected cell for a read.
// Depends on ilst_pkg (entry_t, group sizing).
`default_nettype none

module ilst_gather (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire ilst_pkg::entry_t sel_i [ilst_pkg::CAPACITY],
  output ilst_pkg::entry_t      data_o
);

  localparam int unsigned NumGroups = ilst_pkg::NUM_GROUPS;
  localparam int unsigned GroupSize = ilst_pkg::GROUP_SIZE;
  localparam int unsigned Cap       = ilst_pkg::CAPACITY;

  ilst_pkg::entry_t grp_q [NumGroups];
  ilst_pkg::entry_t grp_d [NumGroups];
  ilst_pkg::entry_t acc;

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        if (g * GroupSize + k < Cap) begin
          grp_d[g] = grp_d[g] | sel_i[g * GroupSize + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    acc = '0;
    for (int g = 0; g < NumGroups; g++) begin
      acc = acc | grp_q[g];
    end
  end

  assign data_o = acc;

endmodule

`default_nettype wire

>>> rtl/core/indexed_shift_list_unit.sv
// Indexed shift list: a row of cells that shift together on insert and remove.
// A command transfer loads the cell row and group OR stage, then the result
// register. Throughput: one command per cycle while results are taken.
// Reset: length zero, no result pending; slot contents above the length are
// never read and so are left uncleared. Depends on ilst_pkg, ilst_cmd_if,
// ilst_res_if, ilst_cell and ilst_gather.
`default_nettype none

module indexed_shift_list_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ilst_cmd_if.sink  cmd_i,
  ilst_res_if.source res_o
);

  localparam int unsigned Cap    = ilst_pkg::CAPACITY;
  localparam int unsigned CmpW   = ilst_pkg::CMP_W;
  localparam int unsigned LenW   = ilst_pkg::LEN_W;
  localparam int unsigned CoordW = ilst_pkg::COORD_BITS;
  localparam int unsigned FieldW = ilst_pkg::FIELD_W;
  localparam int unsigned CountW = ilst_pkg::COUNT_W;

  logic [LenW-1:0] len_q, len_d;
  logic [CmpW-1:0] len_c, pos_c, at;
  logic [ilst_pkg::STATUS_W-1:0] status;
  logic ins_ok, rm_ok, rd_ok;
  logic in_fire, stage_adv;

  logic stage_q;
  logic [ilst_pkg::STATUS_W-1:0] pend_status_q;
  logic [CountW-1:0]             pend_count_q;

  logic                          res_valid_q;
  logic [ilst_pkg::STATUS_W-1:0] res_status_q;
  logic [FieldW-1:0]             res_x_q, res_y_q, res_g_q;
  logic [CountW-1:0]             res_count_q;

  ilst_pkg::ctrl_t  ctrl;
  ilst_pkg::entry_t new_ent;
  ilst_pkg::entry_t gathered;
  ilst_pkg::entry_t ent  [Cap];
  ilst_pkg::entry_t sel  [Cap];
  ilst_pkg::entry_t left [Cap];
  ilst_pkg::entry_t right[Cap];

  assign len_c = CmpW'(len_q);
  assign pos_c = CmpW'(cmd_i.position);

  // Decode and range checks for the command on the channel
  always_comb begin
    status = ilst_pkg::ST_OK;
    at     = '0;
    ins_ok = 1'b0;
    rm_ok  = 1'b0;
    rd_ok  = 1'b0;
    unique case (cmd_i.command) inside
      ilst_pkg::CMD_INS_HEAD, ilst_pkg::CMD_INS_TAIL, ilst_pkg::CMD_INS_AT: begin
        if (cmd_i.command == ilst_pkg::CMD_INS_HEAD) begin
          at = '0;
        end else if (cmd_i.command == ilst_pkg::CMD_INS_TAIL) begin
          at = len_c;
        end else begin
          at = pos_c;
        end
        if (len_q == LenW'(Cap)) begin
          status = ilst_pkg::ST_FULL;
        end else if (at > len_c) begin
          status = ilst_pkg::ST_BADIDX;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ilst_pkg::CMD_RM_HEAD, ilst_pkg::CMD_RM_TAIL, ilst_pkg::CMD_RM_AT: begin
        if (cmd_i.command == ilst_pkg::CMD_RM_HEAD) begin
          at = '0;
        end else if (cmd_i.command == ilst_pkg::CMD_RM_TAIL) begin
          at = len_c - 1'b1;
        end else begin
          at = pos_c;
        end
        if (len_q == '0) begin
          status = ilst_pkg::ST_EMPTY;
        end else if (at >= len_c) begin
          status = ilst_pkg::ST_BADIDX;
        end else begin
          rm_ok = 1'b1;
        end
      end
      ilst_pkg::CMD_RD_AT, ilst_pkg::CMD_RD_HEAD, ilst_pkg::CMD_RD_TAIL: begin
        if (cmd_i.command == ilst_pkg::CMD_RD_HEAD) begin
          at = '0;
        end else if (cmd_i.command == ilst_pkg::CMD_RD_TAIL) begin
          at = len_c - 1'b1;
        end else begin
          at = pos_c;
        end
        if (len_q == '0 || at >= len_c) begin
          status = ilst_pkg::ST_BADIDX;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Handshake: the stage may take a command while it hands its own one on
  assign stage_adv   = stage_q && (!res_valid_q || res_o.ready);
  assign cmd_i.ready = !stage_q || stage_adv;
  assign in_fire     = cmd_i.valid && cmd_i.ready;

  assign ctrl.ins  = in_fire && ins_ok;
  assign ctrl.rm   = in_fire && rm_ok;
  assign ctrl.rd   = in_fire && rd_ok;
  assign ctrl.at   = at;
  assign ctrl.len  = len_c;
  assign ctrl.last = len_c - 1'b1;

  assign new_ent.x   = CoordW'(cmd_i.coord_x);
  assign new_ent.y   = CoordW'(cmd_i.coord_y);
  assign new_ent.sym = cmd_i.glyph;

  always_comb begin
    len_d = len_q;
    if (ctrl.ins) begin
      len_d = len_q + 1'b1;
    end else if (ctrl.rm) begin
      len_d = len_q - 1'b1;
    end
  end

  for (genvar g = 0; g < Cap; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left[g] = '0;
    end else begin : g_mid
      assign left[g] = ent[g-1];
    end
    if (g == Cap - 1) begin : g_tail
      assign right[g] = '0;
    end else begin : g_body
      assign right[g] = ent[g+1];
    end

    ilst_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CmpW'(g)),
      .ctrl_i  (ctrl),
      .new_i   (new_ent),
      .left_i  (left[g]),
      .right_i (right[g]),
      .ent_o   (ent[g]),
      .rd_o    (sel[g])
    );
  end

  ilst_gather u_gather (
    .clk_i  (clk_i),
    .load_i (in_fire),
    .sel_i  (sel),
    .data_o (gathered)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      stage_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (in_fire) begin
        stage_q <= 1'b1;
      end else if (stage_adv) begin
        stage_q <= 1'b0;
      end
      if (stage_adv) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_status_q <= status;
      pend_count_q  <= CountW'(len_d);
    end
    if (stage_adv) begin
      res_status_q <= pend_status_q;
      res_x_q      <= FieldW'(gathered.x);
      res_y_q      <= FieldW'(gathered.y);
      res_g_q      <= gathered.sym;
      res_count_q  <= pend_count_q;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.status     = res_status_q;
  assign res_o.read_x     = res_x_q;
  assign res_o.read_y     = res_y_q;
  assign res_o.read_glyph = res_g_q;
  assign res_o.count      = res_count_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(Cap))
    else $error("list length beyond capacity");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> len_q == LenW'($past(len_q) + 1'b1))
    else $error("insert did not grow the list by one");

  a_idle_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.ins && !ctrl.rm |=> $stable(len_q))
    else $error("length moved without an insert or remove");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != ilst_pkg::ST_OK |->
      res_o.read_x == '0 && res_o.read_y == '0 && res_o.read_glyph == '0)
    else $error("failed command returned read data");

endmodule

`default_nettype wire

>>> test/indexed_shift_list_mirror.sv
// Shadow copy of the indexed shift list: follows every command transfer and
// checks each result transfer against the entry and size it should report.
// Depends on ilst_pkg, ilst_cmd_if and ilst_res_if.
`timescale 1ns / 1ps

module indexed_shift_list_mirror (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilst_cmd_if         cmd_i,
  ilst_res_if         res_i,
  output int unsigned mismatches_o,
  output int unsigned owed_o
);

  localparam int unsigned CountW = ilst_pkg::COUNT_W;

  typedef struct packed {
    logic [ilst_pkg::STATUS_W-1:0] status;
    logic [ilst_pkg::FIELD_W-1:0]  read_x;
    logic [ilst_pkg::FIELD_W-1:0]  read_y;
    logic [ilst_pkg::FIELD_W-1:0]  read_glyph;
    logic [ilst_pkg::COUNT_W-1:0]  count;
  } list_reply_t;

  ilst_pkg::entry_t slots [ilst_pkg::CAPACITY];
  int unsigned      fill;
  list_reply_t      owed_replies [$];

  initial begin
    foreach (slots[i]) slots[i] = '0;
    fill         = 0;
    mismatches_o = 0;
    owed_o       = 0;
  end

  // Apply one command to the shadow list and return the result it must give.
  function automatic list_reply_t advance_list(input logic [ilst_pkg::CMD_W-1:0] op,
                                               input logic [ilst_pkg::POS_W-1:0] pos,
                                               input ilst_pkg::entry_t item);
    list_reply_t reply;
    int unsigned at;
    int unsigned i;
    reply = '0;
    case (op)
      ilst_pkg::CMD_INS_HEAD, ilst_pkg::CMD_INS_TAIL, ilst_pkg::CMD_INS_AT: begin
        at = (op == ilst_pkg::CMD_INS_HEAD) ? 0 : (op == ilst_pkg::CMD_INS_TAIL) ? fill : pos;
        // fullness wins over a bad index
        if (fill >= ilst_pkg::CAPACITY) begin
          reply.status = ilst_pkg::ST_FULL;
        end else if (at > fill) begin
          reply.status = ilst_pkg::ST_BADIDX;
        end else begin
          for (i = fill; i > at; i--) slots[i] = slots[i - 1];
          slots[at] = item;
          fill++;
        end
      end
      ilst_pkg::CMD_RM_HEAD, ilst_pkg::CMD_RM_TAIL, ilst_pkg::CMD_RM_AT: begin
        if (fill == 0) begin
          reply.status = ilst_pkg::ST_EMPTY;
        end else begin
          at = (op == ilst_pkg::CMD_RM_HEAD) ? 0 :
               (op == ilst_pkg::CMD_RM_TAIL) ? fill - 1 : pos;
          if (at >= fill) begin
            reply.status = ilst_pkg::ST_BADIDX;
          end else begin
            for (i = at; i + 1 < fill; i++) slots[i] = slots[i + 1];
            slots[fill - 1] = '0;
            fill--;
          end
        end
      end
      ilst_pkg::CMD_RD_AT, ilst_pkg::CMD_RD_HEAD, ilst_pkg::CMD_RD_TAIL: begin
        if (fill == 0) begin
          reply.status = ilst_pkg::ST_BADIDX;
        end else begin
          at = (op == ilst_pkg::CMD_RD_AT) ? pos :
               (op == ilst_pkg::CMD_RD_HEAD) ? 0 : fill - 1;
          if (at >= fill) begin
            reply.status = ilst_pkg::ST_BADIDX;
          end else begin
            reply.read_x     = slots[at].x;
            reply.read_y     = slots[at].y;
            reply.read_glyph = slots[at].sym;
          end
        end
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
    reply.count = fill[ilst_pkg::COUNT_W-1:0];
    return reply;
  endfunction

  task automatic compare_field(input string name, input logic [CountW-1:0] want,
                               input logic [CountW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch_transfers
    list_reply_t      want;
    ilst_pkg::entry_t item;
    if (!rst_ni) begin
      fill = 0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) begin
        item.x   = cmd_i.coord_x[ilst_pkg::COORD_BITS-1:0];
        item.y   = cmd_i.coord_y[ilst_pkg::COORD_BITS-1:0];
        item.sym = cmd_i.glyph;
        owed_replies.push_back(advance_list(cmd_i.command, cmd_i.position, item));
      end
      if (res_i.valid && res_i.ready) begin
        if (owed_replies.size() == 0) begin
          $error("result transfer with no command outstanding: status %0d count %0d",
                 res_i.status, res_i.count);
          mismatches_o++;
        end else begin
          want = owed_replies.pop_front();
          compare_field("status", CountW'(want.status), CountW'(res_i.status));
          compare_field("read_x", CountW'(want.read_x), CountW'(res_i.read_x));
          compare_field("read_y", CountW'(want.read_y), CountW'(res_i.read_y));
          compare_field("read_glyph", CountW'(want.read_glyph),
                        CountW'(res_i.read_glyph));
          compare_field("count", want.count, res_i.count);
        end
      end
    end
    owed_o <= owed_replies.size();
  end

endmodule

>>> test/indexed_shift_list_unit_test.sv
// Top of the indexed shift list test: clock, reset, command traffic and result
// back-pressure; verdict from the shadow list. Depends on ilst_pkg, both
// channel interfaces, indexed_shift_list_unit and indexed_shift_list_mirror.
`timescale 1ns / 1ps

module indexed_shift_list_unit_test;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned CMD_BITS     = ilst_pkg::CMD_W;
  localparam int unsigned POS_BITS     = ilst_pkg::POS_W;
  localparam int unsigned BYTE_BITS    = ilst_pkg::FIELD_W;
  localparam logic [ilst_pkg::CMD_W-1:0] CMD_LAST_CODE  = '1;
  localparam logic [ilst_pkg::CMD_W-1:0] CMD_SPARE_CODE = ilst_pkg::CMD_RD_TAIL + 1'b1;

  typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SHRINK} traffic_mix_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mirror_errors;
  int unsigned replies_owed;
  int unsigned occupancy;
  int unsigned random_sent;
  int unsigned phase;
  int unsigned sink_hold  = 0;
  int unsigned idle_count = 0;
  bit          steady_flow;

  ilst_cmd_if cmd_if ();
  ilst_res_if res_if ();

  indexed_shift_list_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  indexed_shift_list_mirror mirror (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .mismatches_o (mirror_errors),
    .owed_o       (replies_owed)
  );

  always #2 clk_i = ~clk_i;

  // Mostly short pauses, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Offer one command and hold it until the transfer; track the list size
  // only to steer the random traffic.
  task automatic issue(input logic [ilst_pkg::CMD_W-1:0] op,
                       input logic [ilst_pkg::POS_W-1:0] pos,
                       input logic [ilst_pkg::FIELD_W-1:0] x,
                       input logic [ilst_pkg::FIELD_W-1:0] y,
                       input logic [ilst_pkg::FIELD_W-1:0] g);
    if (!steady_flow && $urandom_range(0, 99) < 30) begin
      cmd_if.valid <= 1'b0;
      repeat (draw_gap()) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= op;
    cmd_if.position <= pos;
    cmd_if.coord_x  <= x;
    cmd_if.coord_y  <= y;
    cmd_if.glyph    <= g;
    do @(posedge clk_i); while (!cmd_if.ready);
    case (op)
      ilst_pkg::CMD_INS_HEAD, ilst_pkg::CMD_INS_TAIL:
        if (occupancy < ilst_pkg::CAPACITY) occupancy++;
      ilst_pkg::CMD_INS_AT:
        if (occupancy < ilst_pkg::CAPACITY && pos <= occupancy) occupancy++;
      ilst_pkg::CMD_RM_HEAD, ilst_pkg::CMD_RM_TAIL: if (occupancy > 0) occupancy--;
      ilst_pkg::CMD_RM_AT: if (occupancy > 0 && pos < occupancy) occupancy--;
      default: ;
    endcase
  endtask

  task automatic issue_random(input traffic_mix_e mix);
    int unsigned                  roll;
    int unsigned                  ins_pct;
    int unsigned                  rm_pct;
    int unsigned                  top_pos;
    logic [ilst_pkg::CMD_W-1:0]   op;
    logic [ilst_pkg::POS_W-1:0]   pos;
    ins_pct = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 15 : 40;
    rm_pct  = (mix == MIX_GROW) ? 12 : (mix == MIX_SHRINK) ? 70 : 35;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      op = ilst_pkg::CMD_INS_HEAD + CMD_BITS'($urandom_range(0, 2));
    end else if (roll < ins_pct + rm_pct) begin
      op = ilst_pkg::CMD_RM_HEAD + CMD_BITS'($urandom_range(0, 2));
    end else if (roll < 96) begin
      op = ilst_pkg::CMD_RD_AT + CMD_BITS'($urandom_range(0, 2));
    end else begin
      op = CMD_BITS'($urandom_range(CMD_SPARE_CODE, CMD_LAST_CODE));
    end
    // keep most indices inside the list so that entries really move
    if ($urandom_range(0, 99) < 85) begin
      if (op == ilst_pkg::CMD_INS_AT) top_pos = occupancy;
      else top_pos = (occupancy == 0) ? 0 : occupancy - 1;
      if (top_pos > 2 ** POS_BITS - 1) top_pos = 2 ** POS_BITS - 1;
      pos = POS_BITS'($urandom_range(0, top_pos));
    end else begin
      pos = POS_BITS'($urandom());
    end
    issue(op, pos, BYTE_BITS'($urandom()), BYTE_BITS'($urandom()),
          BYTE_BITS'($urandom()));
    random_sent++;
  endtask

  // Result side: random stalls unless the phase runs at full rate
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      res_if.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
      res_if.ready <= 1'b0;
      sink_hold <= draw_gap() - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_count <= 0;
    end else if (idle_count + 1 >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    cmd_if.valid    = 1'b0;
    cmd_if.command  = ilst_pkg::CMD_INS_HEAD;
    cmd_if.position = '0;
    cmd_if.coord_x  = '0;
    cmd_if.coord_y  = '0;
    cmd_if.glyph    = '0;
    res_if.ready    = 1'b0;
    occupancy       = 0;
    random_sent     = 0;
    steady_flow     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every remove and read must be refused
    issue(ilst_pkg::CMD_RM_HEAD, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RM_TAIL, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RM_AT, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RD_AT, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RD_HEAD, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RD_TAIL, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_INS_AT, 8'd1, 8'h11, 8'h22, 8'h33);
    // build a short list, index insert at the length appends
    issue(ilst_pkg::CMD_INS_AT, 8'd0, 8'hff, 8'h00, 8'hff);
    issue(ilst_pkg::CMD_INS_HEAD, 8'd0, 8'h00, 8'hff, 8'h00);
    issue(ilst_pkg::CMD_INS_TAIL, 8'd0, 8'ha5, 8'h5a, 8'h3c);
    issue(ilst_pkg::CMD_INS_AT, 8'd1, 8'h12, 8'h34, 8'h56);
    issue(ilst_pkg::CMD_INS_AT, 8'd4, 8'h81, 8'h7e, 8'hc3);
    issue(ilst_pkg::CMD_INS_AT, 8'd255, 8'h01, 8'h02, 8'h03);
    issue(ilst_pkg::CMD_RD_AT, 8'd2, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RD_HEAD, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RD_TAIL, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RD_AT, 8'd5, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RD_AT, 8'd255, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RM_AT, 8'd5, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RM_AT, 8'd255, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RM_AT, 8'd1, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RM_HEAD, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(ilst_pkg::CMD_RM_TAIL, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(CMD_SPARE_CODE, 8'd7, 8'hde, 8'had, 8'hbe);
    issue(CMD_LAST_CODE, 8'd0, 8'hff, 8'hff, 8'hff);

    // alternate mixed traffic with runs up to full and back down to empty
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      case (phase % 4)
        0: repeat (150) if (random_sent < RANDOM_ITEMS) issue_random(MIX_BALANCED);
        1: begin
          while (occupancy < ilst_pkg::CAPACITY && random_sent < RANDOM_ITEMS)
            issue_random(MIX_GROW);
          repeat (12) if (random_sent < RANDOM_ITEMS) issue_random(MIX_GROW);
        end
        2: repeat (100) if (random_sent < RANDOM_ITEMS) issue_random(MIX_BALANCED);
        default: begin
          while (occupancy > 0 && random_sent < RANDOM_ITEMS) issue_random(MIX_SHRINK);
          repeat (12) if (random_sent < RANDOM_ITEMS) issue_random(MIX_SHRINK);
        end
      endcase
      phase++;
    end
    cmd_if.valid <= 1'b0;

    do @(posedge clk_i); while (replies_owed != 0);
    repeat (8) @(posedge clk_i);
    if (mirror_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
